[rtl/npc_pkg.sv]
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types, codes and helpers for the nearest palette colour unit.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  // Field widths
  localparam int COMP_W  = 8;
  localparam int QUERY_W = 10;
  localparam int IDX_W   = 8;
  localparam int VALUE_W = 24;
  localparam int DEPTH_W = 3;
  localparam int DIST_W  = 18;  // 3 * 255^2 fits in 18 bits

  // Default palette size
  localparam int PALETTE_ENTRIES_DEF = 256;

  // Close-match threshold that ends a search
  localparam logic [DIST_W-1:0] DIST_CLOSE = DIST_W'(8);
  // Start distance: above any real distance
  localparam logic [DIST_W-1:0] DIST_START = '1;

  localparam logic [COMP_W-1:0] COMP_MAX = 8'd255;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  // Screen depth codes
  localparam logic [DEPTH_W-1:0] DEPTH_PALETTE = 3'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_RGB565  = 3'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_RGB888  = 3'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET   = DEPTH_PALETTE;

  // Search item moving along the cell row
  typedef struct packed {
    logic              valid;
    logic              done;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [DIST_W-1:0] best;
    logic [IDX_W-1:0]  idx;
  } tok_t;

  // Palette write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pal_wr_t;

  // Saturate a query component to 255
  function automatic logic [COMP_W-1:0] sat_comp(input logic [QUERY_W-1:0] v);
    logic [COMP_W-1:0] r;
    if (v > QUERY_W'(COMP_MAX)) begin
      r = COMP_MAX;
    end else begin
      r = v[COMP_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/npc_cell.sv]
// ----------------------------------------------------------------------------
// npc_cell
// One palette entry with its distance check; passes the search item on.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire npc_pkg::pal_wr_t wr,
  input  wire npc_pkg::tok_t   tok_in,
  output      npc_pkg::tok_t   tok_out
);
  import npc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [COMP_W-1:0] red_r, green_r, blue_r;
  tok_t              tok_r, tok_nxt;

  logic [COMP_W-1:0]   dr, dg, db;
  logic [2*COMP_W-1:0] sr, sg, sb;
  logic [DIST_W-1:0]   sq_dist;

  // Load the stored entry on a matching write
  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == MY_IDX) begin
      red_r   <= wr.red;
      green_r <= wr.green;
      blue_r  <= wr.blue;
    end
  end

  // Squared RGB distance to the stored entry
  always_comb begin
    dr   = (red_r   > tok_in.red)   ? red_r   - tok_in.red   : tok_in.red   - red_r;
    dg   = (green_r > tok_in.green) ? green_r - tok_in.green : tok_in.green - green_r;
    db   = (blue_r  > tok_in.blue)  ? blue_r  - tok_in.blue  : tok_in.blue  - blue_r;
    sr   = dr * dr;
    sg   = dg * dg;
    sb   = db * db;
    sq_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  end

  // Take a strictly better entry; stop the search on a close match
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.done && sq_dist < tok_in.best) begin
      tok_nxt.best = sq_dist;
      tok_nxt.idx  = MY_IDX;
      tok_nxt.done = (sq_dist < DIST_CLOSE);
    end
  end

  // Advance the item to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.done  <= tok_nxt.done;
    tok_r.red   <= tok_nxt.red;
    tok_r.green <= tok_nxt.green;
    tok_r.blue  <= tok_nxt.blue;
    tok_r.best  <= tok_nxt.best;
    tok_r.idx   <= tok_nxt.idx;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

[rtl/nearest_palette_colour_unit.sv]
// A find at palette depth walks its item along the cell row one cell per cycle;
// its result is then registered from the output of the last cell.
// Other finds show their result in the cycle after acceptance; writes are
// registered in the addressed cell. Only one palette search runs at a time.
// Reset: synchronous, active low; clears handshake state and sets depth to 1.
// The palette is undefined after reset until written.
// ----------------------------------------------------------------------------
// nearest_palette_colour_unit
// Maps a query colour to a pixel value by palette search or direct packing.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_colour_unit #(
  parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic [npc_pkg::DEPTH_W-1:0]  cfg_wr_data,
  // Input channel
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         in_operation,
  input  wire logic [npc_pkg::IDX_W-1:0]    in_entry_index,
  input  wire logic [npc_pkg::COMP_W-1:0]   in_entry_red,
  input  wire logic [npc_pkg::COMP_W-1:0]   in_entry_green,
  input  wire logic [npc_pkg::COMP_W-1:0]   in_entry_blue,
  input  wire logic [npc_pkg::QUERY_W-1:0]  in_query_red,
  input  wire logic [npc_pkg::QUERY_W-1:0]  in_query_green,
  input  wire logic [npc_pkg::QUERY_W-1:0]  in_query_blue,
  // Result channel
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [npc_pkg::VALUE_W-1:0]  out_colour_value,
  output      logic                         out_not_found
);
  import npc_pkg::*;

  logic [DEPTH_W-1:0] depth_r;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               nf_r, nf_nxt;

  logic               in_acc, find_acc;
  logic [COMP_W-1:0]  qr, qg, qb;
  pal_wr_t            wr;
  tok_t               tok [PALETTE_ENTRIES+1];

  // Hold finds while a search runs or a result waits; writes wait only on a search
  assign in_stall = busy_r | ((in_operation == OP_FIND) & out_valid_r);
  assign in_acc   = in_valid & ~in_stall;
  assign find_acc = in_acc & (in_operation == OP_FIND);

  assign qr = sat_comp(in_query_red);
  assign qg = sat_comp(in_query_green);
  assign qb = sat_comp(in_query_blue);

  // Broadcast palette writes to the cell row
  always_comb begin
    wr.en    = in_acc & (in_operation == OP_WRITE);
    wr.idx   = in_entry_index;
    wr.red   = in_entry_red;
    wr.green = in_entry_green;
    wr.blue  = in_entry_blue;
  end

  // Launch a palette search into the first cell
  always_comb begin
    tok[0].valid = find_acc & (depth_r == DEPTH_PALETTE);
    tok[0].done  = 1'b0;
    tok[0].red   = qr;
    tok[0].green = qg;
    tok[0].blue  = qb;
    tok[0].best  = DIST_START;
    tok[0].idx   = '0;
  end

  // Row of palette cells
  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npc_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Result register and search busy flag
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    value_nxt     = value_r;
    nf_nxt        = nf_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (tok[PALETTE_ENTRIES].valid) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      value_nxt     = VALUE_W'(tok[PALETTE_ENTRIES].idx);
      nf_nxt        = 1'b0;
    end else if (find_acc) begin
      unique case (depth_r)
        DEPTH_PALETTE: begin
          busy_nxt = 1'b1;
        end
        DEPTH_RGB565: begin
          out_valid_nxt = 1'b1;
          value_nxt     = {8'd0, qr[7:3], qg[7:2], qb[7:3]};
          nf_nxt        = 1'b0;
        end
        DEPTH_RGB888: begin
          out_valid_nxt = 1'b1;
          value_nxt     = {qr, qg, qb};
          nf_nxt        = 1'b0;
        end
        default: begin
          out_valid_nxt = 1'b1;
          value_nxt     = '0;
          nf_nxt        = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= DEPTH_RESET;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        depth_r <= cfg_wr_data;
      end
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r <= value_nxt;
    nf_r    <= nf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_colour_value = value_r;
  assign out_not_found    = nf_r;

endmodule

`default_nettype wire

[rtl/npc_checker.sv]
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks for the nearest palette colour unit.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        in_operation,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [npc_pkg::VALUE_W-1:0] out_colour_value,
  input wire logic                        out_not_found
);
  import npc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_colour_value)
                               && $stable(out_not_found))
    else $error("stalled result changed");

  // Drop the result channel on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Unsupported depth gives a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_found |-> out_colour_value == '0)
    else $error("not found with nonzero value");

  // An accepted find blocks the next find
  a_find_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == OP_FIND
      |=> in_stall || in_operation == OP_WRITE)
    else $error("find taken while previous find pending");

  // Drop the result once taken; only one result is ever pending
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("second result without a new find");

endmodule

bind nearest_palette_colour_unit npc_checker u_npc_checker (.*);

`default_nettype wire
